FILE: hw/rtl/mru_pkg.sv
// Package for the MRU list with pinned entries.
// Holds payload structs, status codes, controller states and the
// controller/datapath command and status structs. No dependencies.
package mru_pkg;

  localparam int KEY_W       = 32;
  localparam int LIMIT_W     = 6;
  localparam int LIMIT_RESET = 20;
  localparam int MAX_RESULTS = 32;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_PIN    = 2'd2,
    CMD_LIST   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_DONE        = 3'd0,
    ST_NOT_FOUND   = 3'd1,
    ST_KEPT_PINNED = 3'd2,
    ST_FULL        = 3'd3,
    ST_ENTRY       = 3'd4,
    ST_EMPTY       = 3'd5
  } status_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [KEY_W-1:0] key;
    logic             force_remove;
    logic             pin_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [KEY_W-1:0] entry_key;
    logic             entry_pinned;
    logic             last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_RD,
    S_FIND_CMP,
    S_DISPATCH,
    S_DEL_RD,
    S_DEL_WR,
    S_DEL_END,
    S_EV_START,
    S_EV_SCAN,
    S_APPEND,
    S_RESP,
    S_L_CHK,
    S_L_LOAD,
    S_L_NEXT
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_POS,
    IDX_TOP,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef struct packed {
    logic    load_item;
    idx_op_t idx_op;
    logic    rd_en;
    logic    rd_next;     // read idx+1 instead of idx
    logic    shift_wr;    // write rdata at idx
    logic    found_set;   // pos <= idx, found <= 1
    logic    save_pin;    // remember pin of matched entry
    logic    pin_write;
    logic    del_commit;
    logic    append;
    logic    want_set;
    logic    want_clr;
    logic    n_clr;
    logic    emit_status;
    status_t status_code;
    logic    emit_entry;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t command;
    logic idx_ge_count;
    logic idx1_ge_count;
    logic idx_zero;
    logic key_match;
    logic found;
    logic pos_pinned;
    logic force_remove;
    logic count_zero;
    logic count_ge_lim;
    logic count_full;
    logic pin_at_idx;
    logic want;
    logic last_entry;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: hw/rtl/mru_datapath.sv
// Datapath of the MRU list: key memory, pin flags, count, index registers
// and the output register. Depends on mru_pkg; driven by mru_ctrl.
module mru_datapath import mru_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  input  in_item_t           in_data,
  input  logic [LIMIT_W-1:0] list_limit,
  output logic               out_valid,
  input  logic               out_ready,
  output out_item_t          out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > LIMIT_W + 1) ? CW : LIMIT_W + 1;

  logic [KEY_W-1:0] mem [DEPTH];
  logic [KEY_W-1:0] rdata;
  logic [DEPTH-1:0] pins;
  logic [CW-1:0]    count;
  logic [CW-1:0]    idx;
  logic [CW-1:0]    idx1;
  logic [CW-1:0]    pos;
  logic             found;
  logic             pinned_save;
  logic             want;
  logic [LW-1:0]    n;
  in_item_t         item;

  logic [AW-1:0]    rd_addr;
  logic [AW-1:0]    wr_addr;
  logic [KEY_W-1:0] wr_data;
  logic             wr_en;
  logic [LW-1:0]    lim_ext;
  logic [LW-1:0]    eff_lim;
  logic [LW-1:0]    list_lim;
  logic [LW-1:0]    count_ext;
  logic [LW-1:0]    total;
  logic [DEPTH-1:0] live_mask;

  assign idx1      = idx + CW'(1);
  assign rd_addr   = cmd.rd_next ? idx1[AW-1:0] : idx[AW-1:0];
  assign wr_en     = cmd.shift_wr | cmd.append;
  assign wr_addr   = cmd.append ? count[AW-1:0] : idx[AW-1:0];
  assign wr_data   = cmd.append ? item.key : rdata;
  assign count_ext = LW'(count);

  always_comb begin
    lim_ext = LW'(list_limit);
    if (lim_ext == '0) begin
      eff_lim = LW'(1);
    end else if (lim_ext > LW'(DEPTH)) begin
      eff_lim = LW'(DEPTH);
    end else begin
      eff_lim = lim_ext;
    end
    list_lim = (eff_lim > LW'(MAX_RESULTS)) ? LW'(MAX_RESULTS) : eff_lim;
    total    = (count_ext < list_lim) ? count_ext : list_lim;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item <= in_data;
    end
    if (cmd.save_pin) begin
      pinned_save <= pins[pos[AW-1:0]];
    end else if (cmd.load_item) begin
      pinned_save <= 1'b0;
    end
    if (cmd.found_set) begin
      pos <= idx;
    end
    unique case (cmd.idx_op)
      IDX_ZERO: idx <= '0;
      IDX_POS:  idx <= pos;
      IDX_TOP:  idx <= count - CW'(1);
      IDX_INC:  idx <= idx1;
      IDX_DEC:  idx <= idx - CW'(1);
      default:  idx <= idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pins      <= '0;
      count     <= '0;
      found     <= 1'b0;
      want      <= 1'b0;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_item) begin
        found <= 1'b0;
      end else if (cmd.found_set) begin
        found <= 1'b1;
      end
      if (cmd.del_commit) begin
        // close the gap at pos; a zero shifts in at the top
        for (int i = 0; i < DEPTH; i++) begin
          if (CW'(i) >= pos) begin
            pins[i] <= (i == DEPTH - 1) ? 1'b0 : pins[(i + 1) % DEPTH];
          end
        end
        count <= count - CW'(1);
      end else if (cmd.append) begin
        pins[count[AW-1:0]] <= pinned_save;
        count <= count + CW'(1);
      end else if (cmd.pin_write) begin
        pins[pos[AW-1:0]] <= item.pin_value;
      end
      if (cmd.want_set) begin
        want <= 1'b1;
      end else if (cmd.want_clr) begin
        want <= 1'b0;
      end
      if (cmd.n_clr) begin
        n <= '0;
      end else if (cmd.emit_entry) begin
        n <= n + LW'(1);
      end
      if (cmd.emit_status || cmd.emit_entry) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_status) begin
      out_data <= '{status: cmd.status_code, entry_key: '0, entry_pinned: 1'b0, last: 1'b1};
    end else if (cmd.emit_entry) begin
      out_data <= '{status: ST_ENTRY, entry_key: rdata, entry_pinned: want,
                    last: (n == total - LW'(1))};
    end
  end

  always_comb begin
    stat.command       = cmd_t'(item.command);
    stat.idx_ge_count  = (idx >= count);
    stat.idx1_ge_count = (idx1 >= count);
    stat.idx_zero      = (idx == '0);
    stat.key_match     = (rdata == item.key);
    stat.found         = found;
    stat.pos_pinned    = pins[pos[AW-1:0]];
    stat.force_remove  = item.force_remove;
    stat.count_zero    = (count == '0);
    stat.count_ge_lim  = (count_ext >= eff_lim);
    stat.count_full    = (count_ext >= LW'(DEPTH));
    stat.pin_at_idx    = pins[idx[AW-1:0]];
    stat.want          = want;
    stat.last_entry    = (n == total - LW'(1));
    stat.out_free      = !out_valid || out_ready;
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      live_mask[i] = (CW'(i) < count);
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");
  a_pins_dead_zero: assert property (@(posedge clk) disable iff (rst)
    (pins & ~live_mask) == '0)
    else $error("pin flag set beyond entry count");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    $past(!rst) |-> (count == $past(count) || count == $past(count) + CW'(1) ||
                     count + CW'(1) == $past(count)))
    else $error("entry count moved by more than one");
`endif

endmodule

FILE: hw/rtl/mru_ctrl.sv
// Controller of the MRU list: sequences search, delete, evict, append,
// pin and list over the datapath. Depends on mru_pkg.
module mru_ctrl import mru_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t  state, state_next;
  state_t  ret, ret_next;
  status_t resp, resp_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      resp  <= ST_DONE;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      resp  <= resp_next;
    end
  end

  always_comb begin
    state_next = state;
    ret_next   = ret;
    resp_next  = resp;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.idx_op = IDX_HOLD;
    cmd.status_code = resp;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cmd.idx_op    = IDX_ZERO;
          state_next    = S_FIND_RD;
        end
      end
      S_FIND_RD: begin
        if (stat.idx_ge_count) begin
          state_next = S_DISPATCH;
        end else begin
          cmd.rd_en  = 1'b1;
          state_next = S_FIND_CMP;
        end
      end
      S_FIND_CMP: begin
        if (stat.key_match) begin
          cmd.found_set = 1'b1;
          state_next    = S_DISPATCH;
        end else begin
          cmd.idx_op = IDX_INC;
          state_next = S_FIND_RD;
        end
      end
      S_DISPATCH: begin
        unique case (stat.command)
          CMD_ADD: begin
            if (stat.found) begin
              cmd.save_pin = 1'b1;
              cmd.idx_op   = IDX_POS;
              ret_next     = S_EV_START;
              state_next   = S_DEL_RD;
            end else begin
              state_next = S_EV_START;
            end
          end
          CMD_REMOVE: begin
            if (!stat.found) begin
              resp_next  = ST_NOT_FOUND;
              state_next = S_RESP;
            end else if (stat.pos_pinned && !stat.force_remove) begin
              resp_next  = ST_KEPT_PINNED;
              state_next = S_RESP;
            end else begin
              cmd.idx_op = IDX_POS;
              resp_next  = ST_DONE;
              ret_next   = S_RESP;
              state_next = S_DEL_RD;
            end
          end
          CMD_PIN: begin
            if (!stat.found) begin
              resp_next = ST_NOT_FOUND;
            end else begin
              cmd.pin_write = 1'b1;
              resp_next     = ST_DONE;
            end
            state_next = S_RESP;
          end
          default: begin
            if (stat.count_zero) begin
              resp_next  = ST_EMPTY;
              state_next = S_RESP;
            end else begin
              cmd.n_clr    = 1'b1;
              cmd.want_set = 1'b1;
              cmd.idx_op   = IDX_TOP;
              state_next   = S_L_CHK;
            end
          end
        endcase
      end
      S_DEL_RD: begin
        if (stat.idx1_ge_count) begin
          state_next = S_DEL_END;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_next  = S_DEL_WR;
        end
      end
      S_DEL_WR: begin
        cmd.shift_wr = 1'b1;
        cmd.idx_op   = IDX_INC;
        state_next   = S_DEL_RD;
      end
      S_DEL_END: begin
        cmd.del_commit = 1'b1;
        state_next     = ret;
      end
      S_EV_START: begin
        if (stat.count_ge_lim) begin
          cmd.idx_op = IDX_ZERO;
          state_next = S_EV_SCAN;
        end else begin
          state_next = S_APPEND;
        end
      end
      S_EV_SCAN: begin
        if (stat.idx_ge_count) begin
          state_next = S_APPEND;
        end else if (!stat.pin_at_idx) begin
          cmd.found_set = 1'b1;
          ret_next      = S_APPEND;
          state_next    = S_DEL_RD;
        end else begin
          cmd.idx_op = IDX_INC;
        end
      end
      S_APPEND: begin
        if (stat.count_full) begin
          resp_next = ST_FULL;
        end else begin
          cmd.append = 1'b1;
          resp_next  = ST_DONE;
        end
        state_next = S_RESP;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.emit_status = 1'b1;
          state_next      = S_IDLE;
        end
      end
      S_L_CHK: begin
        if (stat.pin_at_idx == stat.want) begin
          cmd.rd_en  = 1'b1;
          state_next = S_L_LOAD;
        end else begin
          state_next = S_L_NEXT;
        end
      end
      S_L_LOAD: begin
        if (stat.out_free) begin
          cmd.emit_entry = 1'b1;
          state_next     = stat.last_entry ? S_IDLE : S_L_NEXT;
        end
      end
      S_L_NEXT: begin
        if (!stat.idx_zero) begin
          cmd.idx_op = IDX_DEC;
          state_next = S_L_CHK;
        end else if (stat.want) begin
          cmd.want_clr = 1'b1;
          cmd.idx_op   = IDX_TOP;
          state_next   = S_L_CHK;
        end else begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

FILE: hw/rtl/mru_list_with_pinning_top.sv
// Top level of the MRU list with pinned entries.
// Holds the APB register and joins mru_ctrl and mru_datapath; uses mru_pkg.
//
// One command is taken at a time. Each starts with a search of the list,
// reading and comparing one stored entry after another through the key
// memory's single read port; a delete then shifts the entries above the
// hit down, and an add can run a second scan for the oldest unpinned
// entry plus a second delete. Search and delete together cover the list
// once. A list runs the same search, then visits the entries over its two
// passes and delivers its results. A finished result sits in an output
// register, so the next command is accepted while that transaction still
// waits for out_ready.
// Results appear in order with last high on the final one of each command.
// The pin flags and count clear at reset; no clearing pass runs.
module mru_list_with_pinning_top import mru_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LIMIT_W-1:0] list_limit;
  dp_cmd_t            cmd;
  dp_stat_t           stat;

  // addresses with paddr[2] low (0 to 3) all map to the list limit; the others read zero
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {{(32 - LIMIT_W){1'b0}}, list_limit} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      list_limit <= LIMIT_W'(LIMIT_RESET);
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      list_limit <= pwdata[LIMIT_W-1:0];
    end
  end

  mru_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  mru_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (in_data),
    .list_limit (list_limit),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

FILE: verif/tb_mru_list_with_pinning_top.sv
// Testbench for mru_list_with_pinning_top: drives commands and APB writes,
// predicts every result in a scoreboard class. Depends on mru_pkg and the RTL.
module tb_mru_list_with_pinning_top;
  import mru_pkg::*;

  localparam int DEPTH     = 32;
  localparam int CYCLE_CAP = 3000000;

  // Mirror of the MRU store; predicts results and checks them in order.
  class mru_scoreboard;
    logic [KEY_W-1:0] keys[$];
    bit               pins[$];
    int unsigned      limit;
    out_item_t        pending[$];
    int               errors;
    int               checked;
    int               full_seen;
    int               kept_seen;

    function new();
      limit = LIMIT_RESET;
    endfunction

    function void set_limit(int unsigned v);
      limit = v & 63;
    endfunction

    function int lookup(logic [KEY_W-1:0] k);
      foreach (keys[i])
        if (keys[i] == k) return i;
      return -1;
    endfunction

    function void expect_result(status_t s, logic [KEY_W-1:0] k, bit p, bit l);
      out_item_t r;
      r.status       = s;
      r.entry_key    = k;
      r.entry_pinned = p;
      r.last         = l;
      pending = {pending, r};
    endfunction

    function void note_input(in_item_t it);
      int pos;
      int lim;
      int n;
      bit pv;
      bit want;
      pos = lookup(it.key);
      lim = (limit == 0) ? 1 : ((limit > DEPTH) ? DEPTH : limit);
      case (cmd_t'(it.command))
        CMD_ADD: begin
          pv = 1'b0;
          if (pos >= 0) begin
            pv = pins[pos];
            keys.delete(pos);
            pins.delete(pos);
          end
          // evict at most the oldest unpinned entry
          if (keys.size() >= lim) begin
            for (int i = 0; i < keys.size(); i++) begin
              if (!pins[i]) begin
                keys.delete(i);
                pins.delete(i);
                break;
              end
            end
          end
          if (keys.size() >= DEPTH) begin
            expect_result(ST_FULL, '0, 1'b0, 1'b1);
            full_seen++;
          end else begin
            keys = {keys, it.key};
            pins = {pins, pv};
            expect_result(ST_DONE, '0, 1'b0, 1'b1);
          end
        end
        CMD_REMOVE: begin
          if (pos < 0) begin
            expect_result(ST_NOT_FOUND, '0, 1'b0, 1'b1);
          end else if (pins[pos] && !it.force_remove) begin
            expect_result(ST_KEPT_PINNED, '0, 1'b0, 1'b1);
            kept_seen++;
          end else begin
            keys.delete(pos);
            pins.delete(pos);
            expect_result(ST_DONE, '0, 1'b0, 1'b1);
          end
        end
        CMD_PIN: begin
          if (pos < 0) begin
            expect_result(ST_NOT_FOUND, '0, 1'b0, 1'b1);
          end else begin
            pins[pos] = it.pin_value;
            expect_result(ST_DONE, '0, 1'b0, 1'b1);
          end
        end
        default: begin
          if (keys.size() == 0) begin
            expect_result(ST_EMPTY, '0, 1'b0, 1'b1);
          end else begin
            n = 0;
            // pinned newest-first, then unpinned newest-first
            for (int pass = 0; pass < 2; pass++) begin
              want = (pass == 0);
              for (int i = keys.size() - 1; i >= 0; i--) begin
                if (n < lim && pins[i] == want) begin
                  expect_result(ST_ENTRY, keys[i], want, 1'b0);
                  n++;
                end
              end
            end
            pending[pending.size()-1].last = 1'b1;
          end
        end
      endcase
    endfunction

    function void check(out_item_t got);
      out_item_t exp_r;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: unexpected result %p", got);
        return;
      end
      exp_r = pending.pop_front();
      checked++;
      if (got.status !== exp_r.status || got.entry_key !== exp_r.entry_key ||
          got.entry_pinned !== exp_r.entry_pinned || got.last !== exp_r.last) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result %0d expected st=%0d key=%h pin=%b last=%b,",
                   checked, exp_r.status, exp_r.entry_key, exp_r.entry_pinned,
                   exp_r.last);
          $display("       got st=%0d key=%h pin=%b last=%b",
                   got.status, got.entry_key, got.entry_pinned, got.last);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mru_scoreboard    sb;
  bit               quiet;      // no idling on either side while set
  int               cycles;
  int               sent;
  logic [KEY_W-1:0] key_pool[48];

  mru_list_with_pinning_top DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // Watchdog: end the run as failed once the cycle count passes CYCLE_CAP.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: check each accepted transaction, stall at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) sb.check(out_data);
      out_ready <= quiet || ($urandom_range(0, 99) >= 28);
    end
  end

  // Present one command; hold it until accepted, then predict its results.
  task automatic send(cmd_t c, logic [KEY_W-1:0] k, bit f, bit p);
    in_item_t it;
    it.command      = c;
    it.key          = k;
    it.force_remove = f;
    it.pin_value    = p;
    while (!quiet && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_input(it);
    sent++;
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  // APB write of list_limit: setup cycle, then access cycle.
  task automatic write_limit(int unsigned v);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'd0;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_limit(v);
    @(posedge clk);
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    if ($urandom_range(0, 99) < 20) return $urandom;
    return key_pool[$urandom_range(0, 47)];
  endfunction

  task automatic random_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45)      send(CMD_ADD,    pick_key(), $urandom_range(0, 1), $urandom_range(0, 1));
    else if (r < 60) send(CMD_REMOVE, pick_key(), $urandom_range(0, 1), $urandom_range(0, 1));
    else if (r < 82) send(CMD_PIN,    pick_key(), $urandom_range(0, 1), $urandom_range(0, 1));
    else             send(CMD_LIST,   pick_key(), $urandom_range(0, 1), $urandom_range(0, 1));
  endtask

  initial begin
    sb       = new();
    quiet    = 1'b0;
    cycles   = 0;
    sent     = 0;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_data  = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 48; i++) key_pool[i] = $urandom;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty list, extreme keys, re-add, pin, kept and forced removes.
    send(CMD_LIST,   '0, 1'b0, 1'b0);
    send(CMD_ADD,    '0, 1'b0, 1'b0);
    send(CMD_ADD,    '1, 1'b1, 1'b1);
    send(CMD_ADD,    32'h5, 1'b0, 1'b0);
    send(CMD_ADD,    '0, 1'b0, 1'b0);
    send(CMD_PIN,    32'h5, 1'b0, 1'b1);
    send(CMD_PIN,    32'hdead_beef, 1'b0, 1'b1);
    send(CMD_LIST,   '0, 1'b0, 1'b0);
    send(CMD_ADD,    32'h5, 1'b0, 1'b0);
    send(CMD_REMOVE, 32'h5, 1'b0, 1'b0);
    send(CMD_REMOVE, 32'h5, 1'b1, 1'b0);
    send(CMD_REMOVE, 32'h1234_5678, 1'b1, 1'b0);
    send(CMD_PIN,    '1, 1'b0, 1'b0);
    send(CMD_LIST,   '1, 1'b1, 1'b1);

    // Limit of zero acts as one entry.
    write_limit(0);
    send(CMD_ADD,  32'haaaa_5555, 1'b0, 1'b0);
    send(CMD_ADD,  32'h5555_aaaa, 1'b0, 1'b0);
    send(CMD_LIST, '0, 1'b0, 1'b0);

    // Oversize limit clamps to the depth; fill with pinned keys until full.
    write_limit(63);
    for (int i = 0; i < DEPTH; i++) begin
      send(CMD_ADD, key_pool[i], 1'b0, 1'b0);
      send(CMD_PIN, key_pool[i], 1'b0, 1'b1);
    end
    send(CMD_ADD,    key_pool[40], 1'b0, 1'b0);
    send(CMD_REMOVE, key_pool[3], 1'b0, 1'b0);
    send(CMD_LIST,   '0, 1'b0, 1'b0);
    // Lowered limit, all pinned: add rejected; unpinned keys then evicted.
    write_limit(4);
    send(CMD_ADD, key_pool[41], 1'b0, 1'b0);
    send(CMD_PIN, key_pool[0], 1'b0, 1'b0);
    send(CMD_PIN, key_pool[1], 1'b0, 1'b0);
    send(CMD_ADD, key_pool[42], 1'b0, 1'b0);
    send(CMD_ADD, key_pool[43], 1'b0, 1'b0);
    send(CMD_LIST, '0, 1'b0, 1'b0);

    // Random phases, each under its own limit; one phase runs with no idling.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0:       write_limit(32);
        1:       write_limit(1);
        default: write_limit($urandom_range(1, 32));
      endcase
      quiet = (ph == 3);
      for (int n = 0; n < 62; n++) begin
        random_cmd();
        // hold off new commands once until the store has answered everything
        if (ph == 2 && n == 40) drain();
      end
    end
    quiet = 1'b0;

    drain();
    $display("Covered %0d commands, %0d results checked, %0d full rejects, %0d pinned keeps.",
             sent, sb.checked, sb.full_seen, sb.kept_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Mismatches: %0d, missing results: %0d", sb.errors, sb.pending.size());
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
